### rtl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and codes for the stack machine calculator.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned LIMIT_W  = 31;
    localparam int unsigned OPC_W    = 4;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned DEPTH_OW = 11;

    localparam logic [DATA_W-1:0] SIGN_WORD   = 32'h8000_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_INIT = 31'd1000000000;

    localparam logic [OPC_W-1:0] OP_CONST = 4'd0;
    localparam logic [OPC_W-1:0] OP_ADD   = 4'd1;
    localparam logic [OPC_W-1:0] OP_SUB   = 4'd2;
    localparam logic [OPC_W-1:0] OP_MUL   = 4'd3;
    localparam logic [OPC_W-1:0] OP_DIV   = 4'd4;
    localparam logic [OPC_W-1:0] OP_MAX   = 4'd5;
    localparam logic [OPC_W-1:0] OP_MIN   = 4'd6;
    localparam logic [OPC_W-1:0] OP_NEG   = 4'd7;
    localparam logic [OPC_W-1:0] OP_DUP   = 4'd8;
    localparam logic [OPC_W-1:0] OP_SWAP  = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDER  = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVER   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZ   = 3'd3;
    localparam logic [STAT_W-1:0] ST_REJECT = 3'd4;

    typedef struct packed {
        logic [OPC_W-1:0]  op;
        logic [DATA_W-1:0] value;
        logic              reject;
    } t_cmd;

endpackage

### rtl/smc_in_if.sv
// ----------------------------------------------------------------------------
// smc_in_if
// Command channel: one stack command per word.
// ----------------------------------------------------------------------------
interface smc_in_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  operation;
    logic signed [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

### rtl/smc_out_if.sv
// ----------------------------------------------------------------------------
// smc_out_if
// Result channel: stack view and status after each command.
// ----------------------------------------------------------------------------
interface smc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] bottom_value;
    logic signed [31:0] top_value;
    logic        [10:0] stack_depth;
    logic        [2:0]  status;

    modport source (output valid, output bottom_value, output top_value,
                    output stack_depth, output status, input ready);
    modport sink   (input valid, input bottom_value, input top_value,
                    input stack_depth, input status, output ready);
endinterface

### rtl/smc_ram.sv
// ----------------------------------------------------------------------------
// smc_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/smc_front.sv
// ----------------------------------------------------------------------------
// smc_front
// Takes command words, screens constants against the limit, queues them.
// ----------------------------------------------------------------------------
module smc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    smc_in_if.sink                         i_cmd,
    input  logic                           i_cfg_we,
    input  logic [smc_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    output logic                           o_q_valid,
    input  logic                           i_q_ready,
    output smc_pkg::t_cmd                  o_q_cmd
);
    import smc_pkg::*;

    t_cmd                 r_q [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic [LIMIT_W-1:0]   r_limit;
    logic [DATA_W-1:0]    mag;
    t_cmd                 new_cmd;
    logic                 push;
    logic                 pop;

    assign mag = i_cmd.value[DATA_W-1] ? (DATA_W'(0) - DATA_W'(i_cmd.value))
                                       : DATA_W'(i_cmd.value);

    always_comb begin
        new_cmd.op     = i_cmd.operation;
        new_cmd.value  = i_cmd.value;
        new_cmd.reject = (mag >= {1'b0, r_limit}) || (i_cmd.value == SIGN_WORD);
    end

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign pop         = o_q_valid && i_q_ready;
    assign o_q_cmd     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
            r_limit <= LIMIT_INIT;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= new_cmd;
        end
    end
endmodule

### rtl/smc_div.sv
// ----------------------------------------------------------------------------
// smc_div
// Signed truncating divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smc_pkg::DATA_W-1:0]  i_num,
    input  logic [smc_pkg::DATA_W-1:0]  i_den,
    output logic                        o_done,
    output logic [smc_pkg::DATA_W-1:0]  o_quot
);
    import smc_pkg::*;

    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [$clog2(DATA_W)-1:0] r_cnt;
    logic [DATA_W:0]   sh;
    logic [DATA_W:0]   diff;

    assign sh   = {r_rem, r_q[DATA_W-1]};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(DATA_W))'(DATA_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            // work on magnitudes, fix the sign at the end
            r_rem <= '0;
            r_q   <= i_num[DATA_W-1] ? (DATA_W'(0) - i_num) : i_num;
            r_den <= i_den[DATA_W-1] ? (DATA_W'(0) - i_den) : i_den;
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                r_rem <= diff[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= sh[DATA_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (DATA_W'(0) - r_q) : r_q;
endmodule

### rtl/smc_back.sv
// ----------------------------------------------------------------------------
// smc_back
// Runs queued commands on the stack; top two and bottom entries cached.
// ----------------------------------------------------------------------------
module smc_back #(
    parameter int unsigned STACK_DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  smc_pkg::t_cmd  i_q_cmd,
    smc_out_if.source      o_res
);
    import smc_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DIV, S_SWAP2, S_FILL, S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [DW-1:0]     r_depth, n_depth;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_below, n_below;
    logic [DATA_W-1:0] r_bottom, n_bottom;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_ov, n_ov;
    logic [DATA_W-1:0] r_obot, n_obot, r_otop, n_otop;
    logic [DEPTH_OW-1:0] r_odep, n_odep;
    logic [STAT_W-1:0] r_ost, n_ost;

    logic              we;
    logic [DW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [DW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;
    logic [DATA_W-1:0] alu;
    logic              empty, lt2, full;

    smc_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr[AW-1:0]),
        .o_rdata (rdata)
    );

    smc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_top),
        .i_den   (r_below),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign empty = (r_depth == '0);
    assign lt2   = (r_depth < DW'(2));
    assign full  = (r_depth == DW'(STACK_DEPTH));
    // new below after a pop
    assign raddr = r_depth - DW'(3);

    always_comb begin
        case (r_cmd.op)
            OP_ADD:  alu = r_top + r_below;
            OP_SUB:  alu = r_top - r_below;
            OP_MUL:  alu = r_top * r_below;
            OP_MAX:  alu = ($signed(r_top) > $signed(r_below)) ? r_top : r_below;
            default: alu = ($signed(r_below) > $signed(r_top)) ? r_top : r_below;
        endcase
    end

    assign o_q_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_depth  = r_depth;
        n_top    = r_top;
        n_below  = r_below;
        n_status = r_status;
        n_ov     = r_ov && !o_res.ready;
        n_obot   = r_obot;
        n_otop   = r_otop;
        n_odep   = r_odep;
        n_ost    = r_ost;
        we       = 1'b0;
        waddr    = r_depth;
        wdata    = r_top;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cmd   = i_q_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_state  = S_DONE;
                unique case (r_cmd.op)
                    OP_CONST: begin
                        if (r_cmd.reject) begin
                            n_status = ST_REJECT;
                        end else if (full) begin
                            n_status = ST_OVER;
                        end else begin
                            we      = 1'b1;
                            wdata   = r_cmd.value;
                            n_below = r_top;
                            n_top   = r_cmd.value;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN: begin
                        if (lt2) begin
                            n_status = ST_UNDER;
                        end else if (r_cmd.op == OP_DIV) begin
                            if (r_below == '0) begin
                                n_status = ST_DIVZ;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end else begin
                            we      = 1'b1;
                            waddr   = r_depth - DW'(2);
                            wdata   = alu;
                            n_top   = alu;
                            n_depth = r_depth - 1'b1;
                            if (r_depth > DW'(2)) begin
                                n_state = S_FILL;
                            end
                        end
                    end
                    OP_NEG: begin
                        if (empty) begin
                            n_status = ST_UNDER;
                        end else begin
                            we    = 1'b1;
                            waddr = r_depth - 1'b1;
                            wdata = DATA_W'(0) - r_top;
                            n_top = wdata;
                        end
                    end
                    OP_DUP: begin
                        if (empty) begin
                            n_status = ST_UNDER;
                        end else if (full) begin
                            n_status = ST_OVER;
                        end else begin
                            we      = 1'b1;
                            n_below = r_top;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                    OP_SWAP: begin
                        if (lt2) begin
                            n_status = ST_UNDER;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_depth - 1'b1;
                            wdata   = r_below;
                            n_top   = r_below;
                            n_below = r_top;
                            n_state = S_SWAP2;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    we      = 1'b1;
                    waddr   = r_depth - DW'(2);
                    wdata   = div_q;
                    n_top   = div_q;
                    n_depth = r_depth - 1'b1;
                    n_state = (r_depth > DW'(2)) ? S_FILL : S_DONE;
                end
            end
            S_SWAP2: begin
                we      = 1'b1;
                waddr   = r_depth - DW'(2);
                wdata   = r_below;
                n_state = S_DONE;
            end
            S_FILL: begin
                n_below = rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_obot  = empty ? SIGN_WORD : r_bottom;
                    n_otop  = empty ? SIGN_WORD : r_top;
                    n_odep  = DEPTH_OW'(r_depth);
                    n_ost   = r_status;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_bottom = (we && waddr == '0) ? wdata : r_bottom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_ov    <= n_ov;
        end
        r_cmd    <= n_cmd;
        r_top    <= n_top;
        r_below  <= n_below;
        r_bottom <= n_bottom;
        r_status <= n_status;
        r_obot   <= n_obot;
        r_otop   <= n_otop;
        r_odep   <= n_odep;
        r_ost    <= n_ost;
    end

    assign o_res.valid        = r_ov;
    assign o_res.bottom_value = r_obot;
    assign o_res.top_value    = r_otop;
    assign o_res.stack_depth  = r_odep;
    assign o_res.status       = r_ost;
endmodule

### rtl/stack_machine_calculator.sv
// ----------------------------------------------------------------------------
// stack_machine_calculator
// Stack machine on 32-bit wrapping integers, one result word per command.
// ----------------------------------------------------------------------------
//  channel  dir  words
//  i_cmd    in   operation, value
//  o_res    out  bottom_value, top_value, stack_depth, status
//  cfg      in   i_cfg_we / i_cfg_wdata : const_limit
//
//  the execute sequencer runs idle, execute and done for a command, swap adds
//  a second write, a binary command that pops down to two or more entries a
//  fill (stack ram re-read), division a wait on the bit-serial divider
//  a two-word queue lets commands arrive while the sequencer or output stalls
//  synchronous reset empties the stack and sets the limit to 1000000000
// ----------------------------------------------------------------------------
module stack_machine_calculator #(
    parameter int unsigned STACK_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smc_in_if.sink       i_cmd,
    smc_out_if.source    o_res,
    input  logic         i_cfg_we,
    input  logic [30:0]  i_cfg_wdata
);
    import smc_pkg::*;

    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    smc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_q_cmd     (q_cmd)
    );

    smc_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_cmd   (q_cmd),
        .o_res     (o_res)
    );
endmodule
